// ===== rtl/core/bmc_pkg.sv =====
package bmc_pkg;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE         = 3'd0,
    ST_WOULD_BLOCK  = 3'd1,
    ST_PARKED       = 3'd2,
    ST_CLOSED_EMPTY = 3'd3,
    ST_SEND_CLOSED  = 3'd4,
    ST_CLOSE_TWICE  = 3'd5,
    ST_WAITERS_FULL = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_CLOSE
  } back_state_t;

  localparam int unsigned CAP_W = 7;

  // back-end status seen by the top level
  typedef struct packed {
    logic rx_nonempty;
    logic tx_nonempty;
    logic fill_ok;
    logic idle;
  } back_status_t;

endpackage

// ===== rtl/core/bmc_ifs.sv =====
interface bmc_req_if #(
  parameter int unsigned TW = 4,
  parameter int unsigned DW = 32
);
  logic          valid;
  logic          ready;
  logic [1:0]    operation;
  logic [TW-1:0] thread_id;
  logic [DW-1:0] payload;
  logic          may_block;

  modport source (output valid, operation, thread_id, payload, may_block, input ready);
  modport sink   (input valid, operation, thread_id, payload, may_block, output ready);
endinterface

interface bmc_rsp_if #(
  parameter int unsigned TW = 4,
  parameter int unsigned DW = 32
);
  logic          valid;
  logic          ready;
  logic [TW-1:0] target_thread;
  logic [2:0]    status;
  logic [DW-1:0] data_out;
  logic          got_value;
  logic          last;

  modport source (output valid, target_thread, status, data_out, got_value, last,
                  input ready);
  modport sink   (input valid, target_thread, status, data_out, got_value, last,
                  output ready);
endinterface

interface bmc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bmc_pkg::CAP_W-1:0]   capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/core/bmc_front.sv =====
module bmc_front #(
  parameter int unsigned TW = 4,
  parameter int unsigned DW = 32
) (
  input  logic      clk,
  input  logic      rst,
  bmc_req_if.sink   req,
  bmc_req_if.source cmd
);

  logic [1:0]    q_op   [2];
  logic [TW-1:0] q_tid  [2];
  logic [DW-1:0] q_pay  [2];
  logic          q_blk  [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;
  logic          op_ok;

  assign req.ready = (cnt != 2'd2);
  // unknown opcodes produce no result: dropped here
  assign op_ok = (req.operation == bmc_pkg::OP_SEND) ||
                 (req.operation == bmc_pkg::OP_RECV) ||
                 (req.operation == bmc_pkg::OP_CLOSE);
  assign push = req.valid && req.ready && op_ok;
  assign pop  = cmd.valid && cmd.ready;

  assign cmd.valid     = (cnt != 2'd0);
  assign cmd.operation = q_op[rd_ptr];
  assign cmd.thread_id = q_tid[rd_ptr];
  assign cmd.payload   = q_pay[rd_ptr];
  assign cmd.may_block = q_blk[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]  <= req.operation;
      q_tid[wr_ptr] <= req.thread_id;
      q_pay[wr_ptr] <= req.payload;
      q_blk[wr_ptr] <= req.may_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (!push && pop) cnt <= cnt - 2'd1;
    end
  end

endmodule

// ===== rtl/core/bmc_back.sv =====
module bmc_back #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned THREADS   = 16,
  parameter int unsigned TW        = 4,
  parameter int unsigned DW        = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  bmc_req_if.sink                cmd,
  bmc_cfg_if.sink                cfg,
  bmc_rsp_if.source              rsp,
  output bmc_pkg::back_status_t  stat
);

  localparam int unsigned SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW0  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW   = (CW0 > bmc_pkg::CAP_W) ? CW0 : bmc_pkg::CAP_W;
  localparam int unsigned CNW  = $clog2(THREADS + 1);

  bmc_pkg::back_state_t state, state_next;

  logic [DW-1:0] ring [MAX_SLOTS];
  logic [DW-1:0] ring_rd;
  logic [CW-1:0] live_cap;
  logic [CW-1:0] fill;
  logic [SW-1:0] wslot;
  logic [SW-1:0] rslot;
  logic          closed;

  logic [TW-1:0]  rx_tid  [THREADS];
  logic [TW-1:0]  tx_tid  [THREADS];
  logic [DW-1:0]  tx_data [THREADS];
  logic [TW-1:0]  rx_head, tx_head;
  logic [CNW-1:0] rx_cnt, tx_cnt;

  logic [1:0]    op_q;
  logic [TW-1:0] tid_q;
  logic [DW-1:0] pay_q;
  logic          blk_q;

  // pending results
  logic [TW-1:0]     r1_tid, r2_tid;
  bmc_pkg::status_e  r1_st, r2_st;
  logic [DW-1:0]     r1_data, r2_data;
  logic              r1_got, r2_got;
  logic              has2;

  logic [TW-1:0]     o_tid;
  bmc_pkg::status_e  o_st;
  logic [DW-1:0]     o_data;
  logic              o_got;
  logic              o_last;
  logic              o_valid;
  logic              can_push;

  logic [SW-1:0] rslot_nx, wslot_nx;
  logic [TW-1:0] rx_head_nx, tx_head_nx, rx_tail, tx_tail;
  logic [TW:0]   rx_sum, tx_sum;
  logic [CW-1:0] cap_ext;

  assign can_push = !o_valid || rsp.ready;
  assign cmd.ready = (state == bmc_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = o_valid;
  assign rsp.target_thread = o_tid;
  assign rsp.status        = o_st;
  assign rsp.data_out      = o_data;
  assign rsp.got_value     = o_got;
  assign rsp.last          = o_last;

  assign stat.rx_nonempty = (rx_cnt != '0);
  assign stat.tx_nonempty = (tx_cnt != '0);
  assign stat.fill_ok     = (fill <= live_cap);
  assign stat.idle        = (state == bmc_pkg::S_IDLE);

  assign cap_ext = CW'(cfg.capacity);

  always_comb begin
    // slot wrap modulo live capacity
    rslot_nx = (({1'b0, CW'(rslot)} + (CW + 1)'(1)) >= {1'b0, live_cap}) ?
               '0 : SW'(rslot + SW'(1));
    wslot_nx = (({1'b0, CW'(wslot)} + (CW + 1)'(1)) >= {1'b0, live_cap}) ?
               '0 : SW'(wslot + SW'(1));
    rx_head_nx = (rx_head == TW'(THREADS - 1)) ? '0 : TW'(rx_head + TW'(1));
    tx_head_nx = (tx_head == TW'(THREADS - 1)) ? '0 : TW'(tx_head + TW'(1));
    rx_sum  = {1'b0, rx_head} + (TW + 1)'(rx_cnt);
    tx_sum  = {1'b0, tx_head} + (TW + 1)'(tx_cnt);
    rx_tail = (rx_sum >= (TW + 1)'(THREADS)) ? TW'(rx_sum - (TW + 1)'(THREADS)) : TW'(rx_sum);
    tx_tail = (tx_sum >= (TW + 1)'(THREADS)) ? TW'(tx_sum - (TW + 1)'(THREADS)) : TW'(tx_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bmc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bmc_pkg::S_IDLE:
        if (cmd.valid) state_next = bmc_pkg::S_EXEC;
      bmc_pkg::S_EXEC:
        if (op_q == bmc_pkg::OP_CLOSE && !closed) state_next = bmc_pkg::S_CLOSE;
        else state_next = bmc_pkg::S_EMIT;
      bmc_pkg::S_EMIT:
        if (can_push && !has2) state_next = bmc_pkg::S_IDLE;
      bmc_pkg::S_CLOSE:
        if (can_push && rx_cnt == '0 && tx_cnt == '0) state_next = bmc_pkg::S_IDLE;
      default: state_next = bmc_pkg::S_IDLE;
    endcase
  end

  // ring buffer: registered read at the head slot, one write per item
  always_ff @(posedge clk) begin
    if (state == bmc_pkg::S_IDLE) ring_rd <= ring[rslot];
    if (state == bmc_pkg::S_EXEC && op_q == bmc_pkg::OP_SEND && !closed &&
        rx_cnt == '0 && fill < live_cap)
      ring[wslot] <= pay_q;
    if (state == bmc_pkg::S_EXEC && op_q == bmc_pkg::OP_RECV &&
        !(closed && fill == '0) && tx_cnt != '0 && live_cap != '0)
      ring[rslot] <= tx_data[tx_head];
  end

  always_ff @(posedge clk) begin
    if (state == bmc_pkg::S_IDLE && cmd.valid) begin
      op_q  <= cmd.operation;
      tid_q <= cmd.thread_id;
      pay_q <= cmd.payload;
      blk_q <= cmd.may_block;
    end
    if (state == bmc_pkg::S_EXEC) begin
      r1_tid  <= tid_q;
      r1_st   <= bmc_pkg::ST_DONE;
      r1_data <= '0;
      r1_got  <= 1'b0;
      r2_tid  <= tid_q;
      r2_st   <= bmc_pkg::ST_DONE;
      r2_data <= '0;
      r2_got  <= 1'b0;
      if (op_q == bmc_pkg::OP_SEND) begin
        if (closed) begin
          r1_st <= bmc_pkg::ST_SEND_CLOSED;
        end else if (rx_cnt != '0) begin
          r1_tid  <= rx_tid[rx_head];
          r1_data <= pay_q;
          r1_got  <= 1'b1;
        end else if (fill < live_cap) begin
          r1_st <= bmc_pkg::ST_DONE;
        end else if (!blk_q) begin
          r1_st <= bmc_pkg::ST_WOULD_BLOCK;
        end else if (tx_cnt == CNW'(THREADS)) begin
          r1_st <= bmc_pkg::ST_WAITERS_FULL;
        end else begin
          r1_st <= bmc_pkg::ST_PARKED;
          tx_tid[tx_tail]  <= tid_q;
          tx_data[tx_tail] <= pay_q;
        end
      end else if (op_q == bmc_pkg::OP_RECV) begin
        if (closed && fill == '0) begin
          r1_st <= bmc_pkg::ST_CLOSED_EMPTY;
        end else if (tx_cnt != '0) begin
          r1_tid  <= tx_tid[tx_head];
          r2_data <= (live_cap == '0) ? tx_data[tx_head] : ring_rd;
          r2_got  <= 1'b1;
        end else if (fill != '0) begin
          r1_data <= ring_rd;
          r1_got  <= 1'b1;
        end else if (!blk_q) begin
          r1_st <= bmc_pkg::ST_WOULD_BLOCK;
        end else if (rx_cnt == CNW'(THREADS)) begin
          r1_st <= bmc_pkg::ST_WAITERS_FULL;
        end else begin
          r1_st <= bmc_pkg::ST_PARKED;
          rx_tid[rx_tail] <= tid_q;
        end
      end else begin
        r1_st <= bmc_pkg::ST_CLOSE_TWICE;
      end
    end else if (state == bmc_pkg::S_EMIT && can_push && has2) begin
      r1_tid  <= r2_tid;
      r1_st   <= r2_st;
      r1_data <= r2_data;
      r1_got  <= r2_got;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bmc_pkg::S_EMIT && can_push) begin
      o_tid  <= r1_tid;
      o_st   <= r1_st;
      o_data <= r1_data;
      o_got  <= r1_got;
      o_last <= !has2;
    end else if (state == bmc_pkg::S_CLOSE && can_push) begin
      o_data <= '0;
      o_got  <= 1'b0;
      if (rx_cnt != '0) begin
        o_tid  <= rx_tid[rx_head];
        o_st   <= bmc_pkg::ST_CLOSED_EMPTY;
        o_last <= 1'b0;
      end else if (tx_cnt != '0) begin
        o_tid  <= tx_tid[tx_head];
        o_st   <= bmc_pkg::ST_SEND_CLOSED;
        o_last <= 1'b0;
      end else begin
        o_tid  <= tid_q;
        o_st   <= bmc_pkg::ST_DONE;
        o_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      has2     <= 1'b0;
      live_cap <= '0;
      fill     <= '0;
      wslot    <= '0;
      rslot    <= '0;
      closed   <= 1'b0;
      rx_head  <= '0;
      rx_cnt   <= '0;
      tx_head  <= '0;
      tx_cnt   <= '0;
    end else if (cfg.valid) begin
      live_cap <= (cap_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cap_ext;
      fill     <= '0;
      wslot    <= '0;
      rslot    <= '0;
      closed   <= 1'b0;
      rx_head  <= '0;
      rx_cnt   <= '0;
      tx_head  <= '0;
      tx_cnt   <= '0;
      if (rsp.ready) o_valid <= 1'b0;
    end else begin
      if (((state == bmc_pkg::S_EMIT) || (state == bmc_pkg::S_CLOSE)) && can_push)
        o_valid <= 1'b1;
      else if (rsp.ready)
        o_valid <= 1'b0;

      case (state)
        bmc_pkg::S_EXEC: begin
          has2 <= 1'b0;
          if (op_q == bmc_pkg::OP_SEND && !closed) begin
            if (rx_cnt != '0) begin
              has2    <= 1'b1;
              rx_head <= rx_head_nx;
              rx_cnt  <= rx_cnt - CNW'(1);
            end else if (fill < live_cap) begin
              wslot <= wslot_nx;
              fill  <= fill + CW'(1);
            end else if (blk_q && tx_cnt != CNW'(THREADS)) begin
              tx_cnt <= tx_cnt + CNW'(1);
            end
          end else if (op_q == bmc_pkg::OP_RECV && !(closed && fill == '0)) begin
            if (tx_cnt != '0) begin
              has2    <= 1'b1;
              tx_head <= tx_head_nx;
              tx_cnt  <= tx_cnt - CNW'(1);
              if (live_cap != '0) begin
                rslot <= rslot_nx;
                wslot <= rslot_nx;
              end
            end else if (fill != '0) begin
              rslot <= rslot_nx;
              fill  <= fill - CW'(1);
            end else if (blk_q && rx_cnt != CNW'(THREADS)) begin
              rx_cnt <= rx_cnt + CNW'(1);
            end
          end else if (op_q == bmc_pkg::OP_CLOSE && !closed) begin
            closed <= 1'b1;
          end
        end
        bmc_pkg::S_EMIT: begin
          if (can_push) has2 <= 1'b0;
        end
        bmc_pkg::S_CLOSE: begin
          if (can_push) begin
            if (rx_cnt != '0) begin
              rx_head <= rx_head_nx;
              rx_cnt  <= rx_cnt - CNW'(1);
            end else if (tx_cnt != '0) begin
              tx_head <= tx_head_nx;
              tx_cnt  <= tx_cnt - CNW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/blocking_message_channel.sv =====
// channel | role   | beat carries
// req     | sink   | operation, thread_id, payload, may_block
// rsp     | source | target_thread, status, data_out, got_value, last
// cfg     | sink   | capacity (always ready)
// A beat waits in a two-entry front queue; the back end takes one item at a time.
// Each item passes S_IDLE (ring read at the head slot), S_EXEC and S_EMIT, which sends
// one or two result beats; a first close passes S_CLOSE, one beat per waiter, then its own.
// rst is synchronous: channel empty, open, capacity zero. A stalled rsp holds
// the back end; the front queue keeps accepting until it is full.
module blocking_message_channel #(
  parameter int unsigned MAX_SLOTS  = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned THREADS    = 16
) (
  input logic       clk,
  input logic       rst,
  bmc_req_if.sink   req,
  bmc_rsp_if.source rsp,
  bmc_cfg_if.sink   cfg
);

  localparam int unsigned TW = $clog2(THREADS);

  bmc_pkg::back_status_t stat;

  bmc_req_if #(.TW(TW), .DW(DATA_WIDTH)) cmd ();

  bmc_front #(.TW(TW), .DW(DATA_WIDTH)) u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd)
  );

  bmc_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .THREADS   (THREADS),
    .TW        (TW),
    .DW        (DATA_WIDTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .rsp  (rsp),
    .stat (stat)
  );

`ifndef NO_ASSERTIONS
  a_one_queue: assert property (@(posedge clk) disable iff (rst)
    !(stat.rx_nonempty && stat.tx_nonempty))
    else $error("both waiter queues occupied");

  a_fill: assert property (@(posedge clk) disable iff (rst) stat.fill_ok)
    else $error("fill count above capacity");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> !stat.rx_nonempty && !stat.tx_nonempty)
    else $error("config write left waiters queued");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NTHR      = 16;
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned SETTLE    = 40;
  // opcode outside the defined set, dropped by the block
  localparam logic [1:0]  OP_UNDEF  = 2'd3;

  logic clk = 1'b0;
  logic rst;

  bmc_req_if req_if();
  bmc_rsp_if rsp_if();
  bmc_cfg_if cfg_if();

  blocking_message_channel u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic [3:0]        tgt;
    bmc_pkg::status_e  st;
    logic [31:0]       data;
    logic              got;
    logic              last;
  } beat_t;

  // channel predictor plus the queue of beats it still owes
  class chan_scoreboard;
    logic [6:0]  cap;
    logic [31:0] ring[SLOTS];
    logic [6:0]  fill;
    logic [5:0]  wr_slot, rd_slot;
    logic        closed;
    logic [3:0]  rx_tid[NTHR];
    logic [3:0]  tx_tid[NTHR];
    logic [31:0] tx_word[NTHR];
    int unsigned rx_head, rx_cnt, tx_head, tx_cnt;
    beat_t       owed[$];
    int unsigned errors;

    function void configure(logic [6:0] v);
      cap = v;
      fill = '0;
      wr_slot = '0;
      rd_slot = '0;
      closed = 1'b0;
      rx_head = 0; rx_cnt = 0;
      tx_head = 0; tx_cnt = 0;
    endfunction

    function int unsigned live_cap();
      return (cap > SLOTS) ? SLOTS : int'(cap);
    endfunction

    function logic [5:0] step_slot(logic [5:0] s);
      return (int'(s) + 1 >= live_cap()) ? 6'd0 : s + 6'd1;
    endfunction

    function void owe(logic [3:0] t, bmc_pkg::status_e s, logic [31:0] d, logic g);
      beat_t b;
      b.tgt = t; b.st = s; b.data = d; b.got = g; b.last = 1'b0;
      owed.push_back(b);
    endfunction

    function void do_send(logic [3:0] tid, logic [31:0] d, logic blk);
      int unsigned p;
      if (closed) begin
        owe(tid, bmc_pkg::ST_SEND_CLOSED, '0, 1'b0);
      end else if (rx_cnt > 0) begin
        p = rx_head; rx_head = (p + 1) % NTHR; rx_cnt--;
        owe(rx_tid[p], bmc_pkg::ST_DONE, d, 1'b1);
        owe(tid, bmc_pkg::ST_DONE, '0, 1'b0);
      end else if (fill < live_cap()) begin
        ring[wr_slot] = d;
        wr_slot = step_slot(wr_slot);
        fill++;
        owe(tid, bmc_pkg::ST_DONE, '0, 1'b0);
      end else if (!blk) begin
        owe(tid, bmc_pkg::ST_WOULD_BLOCK, '0, 1'b0);
      end else if (tx_cnt >= NTHR) begin
        owe(tid, bmc_pkg::ST_WAITERS_FULL, '0, 1'b0);
      end else begin
        p = (tx_head + tx_cnt) % NTHR; tx_cnt++;
        tx_tid[p] = tid; tx_word[p] = d;
        owe(tid, bmc_pkg::ST_PARKED, '0, 1'b0);
      end
    endfunction

    function void do_recv(logic [3:0] tid, logic blk);
      int unsigned p;
      logic [31:0] v;
      if (closed && fill == 0) begin
        owe(tid, bmc_pkg::ST_CLOSED_EMPTY, '0, 1'b0);
      end else if (tx_cnt > 0) begin
        p = tx_head; tx_head = (p + 1) % NTHR; tx_cnt--;
        if (live_cap() == 0) begin
          v = tx_word[p];
        end else begin
          // full buffer: take oldest word, parked sender refills that slot
          v = ring[rd_slot];
          ring[rd_slot] = tx_word[p];
          rd_slot = step_slot(rd_slot);
          wr_slot = rd_slot;
        end
        owe(tx_tid[p], bmc_pkg::ST_DONE, '0, 1'b0);
        owe(tid, bmc_pkg::ST_DONE, v, 1'b1);
      end else if (fill > 0) begin
        v = ring[rd_slot];
        rd_slot = step_slot(rd_slot);
        fill--;
        owe(tid, bmc_pkg::ST_DONE, v, 1'b1);
      end else if (!blk) begin
        owe(tid, bmc_pkg::ST_WOULD_BLOCK, '0, 1'b0);
      end else if (rx_cnt >= NTHR) begin
        owe(tid, bmc_pkg::ST_WAITERS_FULL, '0, 1'b0);
      end else begin
        p = (rx_head + rx_cnt) % NTHR; rx_cnt++;
        rx_tid[p] = tid;
        owe(tid, bmc_pkg::ST_PARKED, '0, 1'b0);
      end
    endfunction

    function void do_close(logic [3:0] tid);
      if (closed) begin
        owe(tid, bmc_pkg::ST_CLOSE_TWICE, '0, 1'b0);
        return;
      end
      closed = 1'b1;
      while (rx_cnt > 0) begin
        owe(rx_tid[rx_head], bmc_pkg::ST_CLOSED_EMPTY, '0, 1'b0);
        rx_head = (rx_head + 1) % NTHR; rx_cnt--;
      end
      while (tx_cnt > 0) begin
        owe(tx_tid[tx_head], bmc_pkg::ST_SEND_CLOSED, '0, 1'b0);
        tx_head = (tx_head + 1) % NTHR; tx_cnt--;
      end
      owe(tid, bmc_pkg::ST_DONE, '0, 1'b0);
    endfunction

    function void note_request(logic [1:0] op, logic [3:0] tid, logic [31:0] d,
                               logic blk);
      int unsigned before_n;
      before_n = owed.size();
      case (op)
        bmc_pkg::OP_SEND:  do_send(tid, d, blk);
        bmc_pkg::OP_RECV:  do_recv(tid, blk);
        bmc_pkg::OP_CLOSE: do_close(tid);
        default: ;
      endcase
      if (owed.size() > before_n) owed[owed.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_beat(logic [3:0] t, logic [2:0] s, logic [31:0] d, logic g, logic l);
      beat_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tgt=%0d st=%0d", t, s));
        return;
      end
      e = owed.pop_front();
      if (t !== e.tgt || s !== e.st || d !== e.data || g !== e.got || l !== e.last)
        report_mismatch($sformatf(
          "got tgt=%0d st=%0d data=%h got=%b last=%b, want %0d %0d %h %b %b",
          t, s, d, g, l, e.tgt, e.st, e.data, e.got, e.last));
    endtask
  endclass

  chan_scoreboard sb = new();

  // response side: random backpressure, quiet stretch, one long hold-off
  bit          rsp_quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      sb.check_beat(rsp_if.target_thread, rsp_if.status, rsp_if.data_out,
                    rsp_if.got_value, rsp_if.last);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= rsp_quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  bit req_quiet = 1'b0;

  task push_request(logic [1:0] op, logic [3:0] tid, logic [31:0] d, logic blk);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.thread_id <= tid;
    req_if.payload   <= d;
    req_if.may_block <= blk;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(op, tid, d, blk);
    gap = req_quiet ? 0 : (($urandom_range(0, 99) < 18) ? $urandom_range(1, 6) : 0);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain_channel();
    req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_capacity(logic [6:0] v);
    drain_channel();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.configure(v);
    cfg_if.valid <= 1'b0;
  endtask

  task random_burst(int unsigned n);
    int unsigned k, send_pct, r;
    logic [1:0]  op;
    for (k = 0; k < n; k++) begin
      if (k % 20 == 0) send_pct = $urandom_range(20, 80);
      r = $urandom_range(0, 999);
      if (r < 15)      op = bmc_pkg::OP_CLOSE;
      else if (r < 30) op = OP_UNDEF;
      else             op = ($urandom_range(0, 99) < send_pct) ? bmc_pkg::OP_SEND
                                                               : bmc_pkg::OP_RECV;
      push_request(op, 4'($urandom_range(0, 15)), $urandom(),
                   $urandom_range(0, 99) < 60);
    end
  endtask

  initial begin
    logic [6:0] caps[6];
    int unsigned i;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.operation <= bmc_pkg::OP_SEND;
    req_if.thread_id <= '0;
    req_if.payload <= '0;
    req_if.may_block <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.capacity <= '0;
    sb.errors = 0;
    sb.configure('0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unbuffered: fill the receiver waiters past full, then close wakes them
    set_capacity(7'd0);
    push_request(bmc_pkg::OP_RECV, 4'd0, '0, 1'b0);
    for (i = 0; i < 17; i++) push_request(bmc_pkg::OP_RECV, 4'(i % 16), '0, 1'b1);
    push_request(bmc_pkg::OP_SEND, 4'd15, 32'hFFFF_FFFF, 1'b0);
    push_request(bmc_pkg::OP_SEND, 4'd3, 32'h0, 1'b0);
    push_request(bmc_pkg::OP_CLOSE, 4'd7, '0, 1'b0);
    push_request(bmc_pkg::OP_SEND, 4'd1, 32'h1234_5678, 1'b1);
    push_request(bmc_pkg::OP_CLOSE, 4'd2, '0, 1'b0);
    push_request(bmc_pkg::OP_RECV, 4'd4, '0, 1'b1);
    push_request(OP_UNDEF, 4'd5, '0, 1'b1);

    // one slot: buffer, park, swap on receive
    set_capacity(7'd1);
    push_request(bmc_pkg::OP_SEND, 4'd1, 32'hA5A5_0001, 1'b0);
    push_request(bmc_pkg::OP_SEND, 4'd2, 32'hA5A5_0002, 1'b0);
    push_request(bmc_pkg::OP_SEND, 4'd2, 32'hA5A5_0003, 1'b1);
    push_request(bmc_pkg::OP_RECV, 4'd9, '0, 1'b0);
    push_request(bmc_pkg::OP_RECV, 4'd9, '0, 1'b0);
    push_request(bmc_pkg::OP_RECV, 4'd9, '0, 1'b0);
    push_request(bmc_pkg::OP_CLOSE, 4'd0, '0, 1'b0);
    push_request(bmc_pkg::OP_RECV, 4'd8, '0, 1'b0);

    caps[0] = 7'd0;  caps[1] = 7'd64; caps[2] = 7'd3;
    caps[3] = 7'd1;  caps[4] = 7'd7;  caps[5] = 7'($urandom_range(2, 64));
    for (i = 0; i < 6; i++) begin
      set_capacity(caps[i]);
      if (i == 1) begin
        // long hold on results while requests keep coming
        hold_req = 1'b1;
        for (int j = 0; j < 30; j++)
          push_request(bmc_pkg::OP_SEND, 4'($urandom_range(0, 15)), $urandom(), 1'b1);
      end
      if (i == 3) begin
        req_quiet = 1'b1;
        rsp_quiet = 1'b1;
      end
      random_burst(34);
      if (i == 2) drain_channel();
      random_burst(34);
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
    end

    drain_channel();
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
